// ===== src/x11sf_pkg.sv =====
// ----------------------------------------------------------------------------
// x11sf_pkg
// Shared types and constants for the X11 server stream framer.
// ----------------------------------------------------------------------------
package x11sf_pkg;

    localparam int OFS_W     = 35;          // width of offsets and lengths
    localparam int LEN_W     = 32;          // width of the reply length field
    localparam int SEQ_W     = 16;          // width of the sequence number

    localparam logic [OFS_W-1:0] SETUP_HDR_LEN = OFS_W'(8);
    localparam logic [OFS_W-1:0] PACKET_LEN    = OFS_W'(32);

    // Byte offsets of the header fields
    localparam logic [OFS_W-1:0] OFS_SEQ_LO = OFS_W'(2);
    localparam logic [OFS_W-1:0] OFS_SEQ_HI = OFS_W'(3);
    localparam logic [OFS_W-1:0] OFS_LEN_LO = OFS_W'(4);
    localparam logic [OFS_W-1:0] OFS_SU_LEN = OFS_W'(6);
    localparam logic [OFS_W-1:0] OFS_LEN_HI = OFS_W'(7);

    // Packet type byte codes
    localparam logic [7:0] TYPE_ERROR = 8'd0;
    localparam logic [7:0] TYPE_REPLY = 8'd1;

    typedef enum logic [1:0] {
        K_SETUP = 2'd0,
        K_ERROR = 2'd1,
        K_REPLY = 2'd2,
        K_EVENT = 2'd3
    } t_kind;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       restart;
    } t_in_item;

endpackage

// ===== src/x11_server_stream_framer_core.sv =====
// ----------------------------------------------------------------------------
// x11_server_stream_framer_core
// Tags each byte of an X11 server-to-client stream with its message kind,
// offset, boundary flags, reply sequence number and message length.
// ----------------------------------------------------------------------------
// The block takes one byte per cycle while i_out_ready does not hold back
// the output and returns one result per byte; each byte passes the input
// register, then the framing stage with its offset increment and 36-bit
// end-of-message compare. Both the input register and the
// result register hold a transaction each, so a new byte is still taken
// while a finished result waits on the output. Assert i_restart with the
// first byte of a connection: that byte opens a set-up reply (8 bytes plus
// four times the 16-bit length in bytes 6 and 7). After it come 32-byte
// packets; type 0 is an error, 1 a reply (lengthened by four times the
// 32-bit length in bytes 4 to 7) and anything else an event. The byte order
// of length and sequence fields follows the little-endian register, which
// should only be written while no byte is in flight.
// ----------------------------------------------------------------------------
module x11_server_stream_framer_core (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // Configuration write channel
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic                        i_little_endian,
    // Byte input channel
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic [7:0]                  i_data_byte,
    input  logic                        i_restart,
    // Tagged byte output channel
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic [1:0]                  o_message_kind,
    output logic [x11sf_pkg::OFS_W-1:0] o_byte_offset,
    output logic                        o_first_byte,
    output logic                        o_last_byte,
    output logic [x11sf_pkg::SEQ_W-1:0] o_reply_sequence,
    output logic [x11sf_pkg::OFS_W-1:0] o_message_length
);
    import x11sf_pkg::*;

    logic     r_little_endian;
    logic     w_take;
    logic     w_item_valid;
    t_in_item w_item;
    t_kind    w_kind;

    // Register writes are always taken
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_little_endian <= 1'b0;
        end else if (i_cfg_valid) begin
            r_little_endian <= i_little_endian;
        end
    end

    // Hold the incoming transaction until the framing stage takes it
    x11sf_in_reg u_in_reg (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_data_byte  (i_data_byte),
        .i_restart    (i_restart),
        .i_take       (w_take),
        .o_item_valid (w_item_valid),
        .o_item       (w_item)
    );

    // Advance message state and register the tagged result
    x11sf_frame u_frame (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_little_endian  (r_little_endian),
        .i_item_valid     (w_item_valid),
        .i_item           (w_item),
        .o_take           (w_take),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_kind           (w_kind),
        .o_byte_offset    (o_byte_offset),
        .o_first_byte     (o_first_byte),
        .o_last_byte      (o_last_byte),
        .o_reply_sequence (o_reply_sequence),
        .o_message_length (o_message_length)
    );

    assign o_message_kind = 2'(w_kind);

    // The first byte of a message always sits at offset zero
    a_first_at_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_first_byte |-> o_byte_offset == '0)
        else $error("first byte flagged away from offset zero");

    // Errors and events are fixed-size packets ending at byte 31
    a_packet_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_last_byte &&
        (o_message_kind == 2'(K_ERROR) || o_message_kind == 2'(K_EVENT))
        |-> o_byte_offset == PACKET_LEN - OFS_W'(1))
        else $error("error or event packet ended at wrong offset");

    // Variable lengths are unknown until the length field is complete
    a_len_known: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_message_length != '0 &&
        (o_message_kind == 2'(K_SETUP) || o_message_kind == 2'(K_REPLY))
        |-> o_byte_offset >= OFS_LEN_HI)
        else $error("message length reported before its field was read");

endmodule

// ===== src/x11sf_in_reg.sv =====
// ----------------------------------------------------------------------------
// x11sf_in_reg
// Input register: captures one byte transaction and holds it until the
// framing stage takes it.
// ----------------------------------------------------------------------------
module x11sf_in_reg (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  logic [7:0]          i_data_byte,
    input  logic                i_restart,
    input  logic                i_take,
    output logic                o_item_valid,
    output x11sf_pkg::t_in_item o_item
);
    import x11sf_pkg::*;

    logic     r_valid;
    t_in_item r_item;

    assign o_in_ready   = !r_valid || i_take;
    assign o_item_valid = r_valid;
    assign o_item       = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_valid <= i_in_valid;
        end
    end

    // Load payload on every accepted transaction
    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_item.data_byte <= i_data_byte;
            r_item.restart   <= i_restart;
        end
    end

endmodule

// ===== src/x11sf_frame.sv =====
// ----------------------------------------------------------------------------
// x11sf_frame
// Framing stage: message state, per-byte tagging and the result register.
// ----------------------------------------------------------------------------
module x11sf_frame (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_little_endian,
    input  logic                        i_item_valid,
    input  x11sf_pkg::t_in_item         i_item,
    output logic                        o_take,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output x11sf_pkg::t_kind            o_kind,
    output logic [x11sf_pkg::OFS_W-1:0] o_byte_offset,
    output logic                        o_first_byte,
    output logic                        o_last_byte,
    output logic [x11sf_pkg::SEQ_W-1:0] o_reply_sequence,
    output logic [x11sf_pkg::OFS_W-1:0] o_message_length
);
    import x11sf_pkg::*;

    // Message state
    logic             r_setup_done;
    logic [OFS_W-1:0] r_offset;
    logic [OFS_W-1:0] r_total;
    t_kind            r_kind;
    logic [LEN_W-1:0] r_len;
    logic [SEQ_W-1:0] r_seq;

    logic             n_setup_done;
    logic [OFS_W-1:0] n_offset;
    logic [OFS_W-1:0] n_total;
    t_kind            n_kind;
    logic [LEN_W-1:0] n_len;
    logic [SEQ_W-1:0] n_seq;

    // Result register
    logic             r_out_valid;
    t_kind            r_o_kind;
    logic [OFS_W-1:0] r_o_offset;
    logic             r_o_first;
    logic             r_o_last;
    logic [SEQ_W-1:0] r_o_seq;
    logic [OFS_W-1:0] r_o_length;

    // Working values
    logic             w_done;
    logic [OFS_W-1:0] w_off;
    logic [OFS_W-1:0] w_total;
    t_kind            w_kind;
    logic [LEN_W-1:0] w_len;
    logic [SEQ_W-1:0] w_seq;
    logic [7:0]       w_b;
    logic [SEQ_W-1:0] w_su_len;
    logic             w_known;
    logic             w_last;
    logic [SEQ_W-1:0] w_seq_out;

    assign o_take = i_item_valid && (!r_out_valid || i_out_ready);

    always_comb begin
        w_b = i_item.data_byte;

        // Restart drops any message in progress
        if (i_item.restart) begin
            w_done  = 1'b0;
            w_off   = '0;
            w_total = SETUP_HDR_LEN;
            w_kind  = K_SETUP;
            w_len   = '0;
            w_seq   = '0;
        end else begin
            w_done  = r_setup_done;
            w_off   = r_offset;
            w_total = r_total;
            w_kind  = r_kind;
            w_len   = r_len;
            w_seq   = r_seq;
        end

        // Start of message: classify
        if (w_off == '0) begin
            w_len = '0;
            w_seq = '0;
            if (!w_done) begin
                w_kind  = K_SETUP;
                w_total = SETUP_HDR_LEN;
            end else begin
                if (w_b == TYPE_ERROR) begin
                    w_kind = K_ERROR;
                end else if (w_b == TYPE_REPLY) begin
                    w_kind = K_REPLY;
                end else begin
                    w_kind = K_EVENT;
                end
                w_total = PACKET_LEN;
            end
        end

        w_su_len  = '0;
        w_seq_out = '0;
        case (w_kind)
            K_SETUP: begin
                if (w_off == OFS_SU_LEN || w_off == OFS_LEN_HI) begin
                    w_len = i_little_endian ? {w_b, w_len[LEN_W-1:8]}
                                            : {w_len[LEN_W-9:0], w_b};
                end
                if (w_off == OFS_LEN_HI) begin
                    w_su_len = i_little_endian ? w_len[LEN_W-1:SEQ_W] : w_len[SEQ_W-1:0];
                    w_total  = SETUP_HDR_LEN + {{(OFS_W-SEQ_W-2){1'b0}}, w_su_len, 2'b00};
                end
            end
            K_REPLY: begin
                if (w_off == OFS_SEQ_LO || w_off == OFS_SEQ_HI) begin
                    w_seq = i_little_endian ? {w_b, w_seq[SEQ_W-1:8]}
                                            : {w_seq[SEQ_W-9:0], w_b};
                end
                if (w_off >= OFS_LEN_LO && w_off <= OFS_LEN_HI) begin
                    w_len = i_little_endian ? {w_b, w_len[LEN_W-1:8]}
                                            : {w_len[LEN_W-9:0], w_b};
                end
                if (w_off == OFS_LEN_HI) begin
                    w_total = PACKET_LEN + {{(OFS_W-LEN_W-2){1'b0}}, w_len, 2'b00};
                end
                if (w_off >= OFS_SEQ_HI) begin
                    w_seq_out = w_seq;
                end
            end
            default: begin
            end
        endcase

        w_known = (w_kind == K_ERROR) || (w_kind == K_EVENT) || (w_off >= OFS_LEN_HI);
        w_last  = ({1'b0, w_off} + (OFS_W+1)'(1)) == {1'b0, w_total};

        n_kind = w_kind;
        n_len  = w_len;
        n_seq  = w_seq;
        if (w_last) begin
            n_setup_done = w_done || (w_kind == K_SETUP);
            n_offset     = '0;
            n_total      = PACKET_LEN;
        end else begin
            n_setup_done = w_done;
            n_offset     = w_off + OFS_W'(1);
            n_total      = w_total;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_setup_done <= 1'b0;
            r_offset     <= '0;
            r_total      <= SETUP_HDR_LEN;
            r_kind       <= K_SETUP;
            r_len        <= '0;
            r_seq        <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (o_take) begin
                r_setup_done <= n_setup_done;
                r_offset     <= n_offset;
                r_total      <= n_total;
                r_kind       <= n_kind;
                r_len        <= n_len;
                r_seq        <= n_seq;
            end
            if (o_take) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take) begin
            r_o_kind   <= w_kind;
            r_o_offset <= w_off;
            r_o_first  <= (w_off == '0);
            r_o_last   <= w_last;
            r_o_seq    <= w_seq_out;
            r_o_length <= w_known ? w_total : '0;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_kind           = r_o_kind;
    assign o_byte_offset    = r_o_offset;
    assign o_first_byte     = r_o_first;
    assign o_last_byte      = r_o_last;
    assign o_reply_sequence = r_o_seq;
    assign o_message_length = r_o_length;

endmodule
